// File: hw/rtl/ted_pkg.sv
`default_nettype none

package ted_pkg;

    localparam int unsigned DataW = 8;
    localparam int unsigned DueW  = 3;
    localparam int unsigned CountW = 2;

    localparam logic [DataW-1:0] Utf8Bom0 = 8'hEF;
    localparam logic [DataW-1:0] Utf8Bom1 = 8'hBB;
    localparam logic [DataW-1:0] Utf8Bom2 = 8'hBF;
    localparam logic [DataW-1:0] ByteFf   = 8'hFF;
    localparam logic [DataW-1:0] ByteFe   = 8'hFE;

    typedef enum logic [2:0] {
        ENC_UNKNOWN    = 3'd0,
        ENC_UTF8_BOM   = 3'd1,
        ENC_UTF16_LE   = 3'd2,
        ENC_UTF16_BE   = 3'd3,
        ENC_UTF8_NOBOM = 3'd4
    } enc_t;

    typedef struct packed {
        logic [DataW-1:0] data_byte;
        logic             last_byte;
    } item_t;

    function automatic logic [DueW-1:0] lead_length(input logic [DataW-1:0] b);
        logic [DueW-1:0] n;
        n = '0;
        if ((b & 8'hE0) == 8'hC0) begin
            n = 3'd1;
        end else if ((b & 8'hF0) == 8'hE0) begin
            n = 3'd2;
        end else if ((b & 8'hF8) == 8'hF0) begin
            n = 3'd3;
        end else if ((b & 8'hFC) == 8'hF8) begin
            n = 3'd4;
        end else if ((b & 8'hFE) == 8'hFC) begin
            n = 3'd5;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ted_state.sv
`default_nettype none

module ted_state
    import ted_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step_en,
    input  wire item_t item,
    output enc_t       code
);

    logic [CountW-1:0] count_reg, count_next;
    logic              utf8_reg, utf8_next;
    logic              le_reg, le_next;
    logic              be_reg, be_next;
    logic [DueW-1:0]   due_reg, due_next;
    logic              invalid_reg, invalid_next;

    logic [CountW-1:0] count_upd;
    logic              utf8_upd, le_upd, be_upd, invalid_upd;
    logic [DueW-1:0]   due_upd;
    logic [DueW-1:0]   lead_n;
    logic [DataW-1:0]  b;

    always_comb begin
        b        = item.data_byte;
        utf8_upd = utf8_reg;
        le_upd   = le_reg;
        be_upd   = be_reg;
        case (count_reg)
            2'd0: begin
                utf8_upd = utf8_reg && (b == Utf8Bom0);
                le_upd   = le_reg && (b == ByteFf);
                be_upd   = be_reg && (b == ByteFe);
            end
            2'd1: begin
                utf8_upd = utf8_reg && (b == Utf8Bom1);
                le_upd   = le_reg && (b == ByteFe);
                be_upd   = be_reg && (b == ByteFf);
            end
            2'd2: begin
                utf8_upd = utf8_reg && (b == Utf8Bom2);
            end
            default: begin
            end
        endcase
        count_upd = (count_reg == 2'd3) ? count_reg : count_reg + 2'd1;

        lead_n      = lead_length(b);
        invalid_upd = invalid_reg;
        due_upd     = due_reg;
        if (!invalid_reg) begin
            if (due_reg == '0) begin
                if (b[7]) begin
                    if (lead_n == '0) begin
                        invalid_upd = 1'b1;
                    end else begin
                        due_upd = lead_n;
                    end
                end
            end else if (b[7:6] != 2'b10) begin
                invalid_upd = 1'b1;
                due_upd     = '0;
            end else begin
                due_upd = due_reg - 3'd1;
            end
        end

        if (count_upd == 2'd3 && utf8_upd) begin
            code = ENC_UTF8_BOM;
        end else if (count_upd >= 2'd2 && le_upd) begin
            code = ENC_UTF16_LE;
        end else if (count_upd >= 2'd2 && be_upd) begin
            code = ENC_UTF16_BE;
        end else if (invalid_upd) begin
            code = ENC_UNKNOWN;
        end else begin
            code = ENC_UTF8_NOBOM;
        end

        count_next   = count_reg;
        utf8_next    = utf8_reg;
        le_next      = le_reg;
        be_next      = be_reg;
        due_next     = due_reg;
        invalid_next = invalid_reg;
        if (step_en) begin
            if (item.last_byte) begin
                count_next   = '0;
                utf8_next    = 1'b1;
                le_next      = 1'b1;
                be_next      = 1'b1;
                due_next     = '0;
                invalid_next = 1'b0;
            end else begin
                count_next   = count_upd;
                utf8_next    = utf8_upd;
                le_next      = le_upd;
                be_next      = be_upd;
                due_next     = due_upd;
                invalid_next = invalid_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            utf8_reg    <= 1'b1;
            le_reg      <= 1'b1;
            be_reg      <= 1'b1;
            due_reg     <= '0;
            invalid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            utf8_reg    <= utf8_next;
            le_reg      <= le_next;
            be_reg      <= be_next;
            due_reg     <= due_next;
            invalid_reg <= invalid_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/text_encoding_detector.sv
// The last byte of a buffer reaches m_tvalid via the input register, then the
// result register. Throughput: 1 byte per cycle; a last byte waits while the
// result register is full. State updates once per byte between the registers.
// Reset: synchronous on aresetn low; clears both registers' valid flags
// and returns the detector to the start of a new buffer.
`default_nettype none

module text_encoding_detector
    import ted_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [2:0] encoding_code, [7:3] zero
);

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg, in_item_next;
    logic  out_valid_reg, out_valid_next;
    enc_t  out_code_reg, out_code_next;
    logic  out_free;
    logic  advance;
    enc_t  code;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign s_tready = !in_valid_reg || advance;

    ted_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .code    (code)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tready) begin
            in_valid_next          = s_tvalid;
            in_item_next.data_byte = s_tdata;
            in_item_next.last_byte = s_tlast;
        end

        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && in_item_reg.last_byte) begin
            out_valid_next = 1'b1;
            out_code_next  = code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_code_reg <= out_code_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_code_reg};

endmodule

`default_nettype wire
